// ----- rtl/wrf_pkg.sv -----
package wrf_pkg;

   localparam int MAX_POINTS   = 64;
   localparam int SLOT_W       = 6;
   localparam int LEN_W        = 7;
   localparam int WAIT_TICKS   = 100;
   localparam int WAIT_W       = 7;
   localparam int CORDIC_STEPS = 16;
   localparam int ITER_W       = $clog2(CORDIC_STEPS);
   localparam int CX_W         = 20;
   localparam int CZ_W         = 26;
   localparam int MUL_W        = 18;
   localparam int PROD_W       = 2 * MUL_W;
   localparam int RAM_W        = 32;

   localparam logic signed [17:0] HALF_TURN  = 18'sd11520;
   localparam logic signed [17:0] FULL_TURN  = 18'sd23040;
   localparam logic [13:0]        SLOW_START = 14'd960;
   localparam logic [13:0]        SLOW_END   = 14'd2880;
   localparam logic signed [14:0] ALIGN_TOL  = 15'sd384;
   localparam logic signed [17:0] TURN_GAIN  = 18'sd25021;
   // ceil(2^19 / 15): exact floor division by 15 for operands below 2^16
   localparam logic signed [17:0] RCP_15     = 18'sd34953;
   localparam logic signed [CZ_W-1:0] QUARTER_Z = 26'sd5898240;

   // Item functions
   localparam logic [1:0] FN_TICK  = 2'd0;
   localparam logic [1:0] FN_START = 2'd1;
   localparam logic [1:0] FN_STOP  = 2'd2;
   localparam logic [1:0] FN_WRITE = 2'd3;

   // Route phases
   localparam logic [2:0] PH_IDLE        = 3'd0;
   localparam logic [2:0] PH_WAIT        = 3'd1;
   localparam logic [2:0] PH_ALIGN_FIRST = 3'd2;
   localparam logic [2:0] PH_DRIVE_FIRST = 3'd3;
   localparam logic [2:0] PH_ALIGN_NEXT  = 3'd4;
   localparam logic [2:0] PH_FOLLOW      = 3'd5;
   localparam logic [2:0] PH_DONE        = 3'd6;

   // Register indexes
   localparam logic [2:0] REG_ROUTE_LEN = 3'd0;
   localparam logic [2:0] REG_ARRIVE    = 3'd1;
   localparam logic [2:0] REG_NOMINAL   = 3'd2;
   localparam logic [2:0] REG_MAX_TURN  = 3'd3;
   localparam logic [2:0] REG_LOOP      = 3'd4;
   localparam logic [2:0] REG_RAMP      = 3'd5;

   // Datapath operations
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
   localparam logic [OP_W-1:0] OP_LD_A     = 5'd2;
   localparam logic [OP_W-1:0] OP_LD_B     = 5'd3;
   localparam logic [OP_W-1:0] OP_DIFF     = 5'd4;
   localparam logic [OP_W-1:0] OP_CINIT    = 5'd5;
   localparam logic [OP_W-1:0] OP_CSTEP    = 5'd6;
   localparam logic [OP_W-1:0] OP_ANGLE    = 5'd7;
   localparam logic [OP_W-1:0] OP_MUL_TURN = 5'd8;
   localparam logic [OP_W-1:0] OP_TURN     = 5'd9;
   localparam logic [OP_W-1:0] OP_MUL_SPD  = 5'd10;
   localparam logic [OP_W-1:0] OP_MUL_RCP  = 5'd11;
   localparam logic [OP_W-1:0] OP_RAMP     = 5'd12;
   localparam logic [OP_W-1:0] OP_MUL_DX   = 5'd13;
   localparam logic [OP_W-1:0] OP_MUL_DY   = 5'd14;
   localparam logic [OP_W-1:0] OP_MUL_THR  = 5'd15;
   localparam logic [OP_W-1:0] OP_ARR      = 5'd16;
   localparam logic [OP_W-1:0] OP_CLR_SPD  = 5'd17;

   typedef struct packed {
      logic [LEN_W-1:0] route_length;
      logic [11:0]      arrive_thr;
      logic [11:0]      nominal;
      logic [12:0]      max_turn;
      logic             loop_route;
      logic [7:0]       ramp_step;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic              diff_pose;
      logic [ITER_W-1:0] iter;
      logic              ram_we;
      logic [SLOT_W-1:0] ram_addr;
   } dp_cmd_type;

   typedef struct packed {
      logic               a_zero;
      logic               aligned;
      logic               arrived;
      logic [11:0]        ramped;
      logic signed [13:0] turn_neg;
   } dp_stat_type;

   // Arctangent of 2^-i in degrees * 65536, rounded.
   function automatic logic signed [CZ_W-1:0] atan_tab(input logic [4:0] idx);
      logic signed [CZ_W-1:0] r;
      case (idx)
         5'd0:  r = 26'sd2949120;
         5'd1:  r = 26'sd1740967;
         5'd2:  r = 26'sd919879;
         5'd3:  r = 26'sd466945;
         5'd4:  r = 26'sd234379;
         5'd5:  r = 26'sd117304;
         5'd6:  r = 26'sd58666;
         5'd7:  r = 26'sd29335;
         5'd8:  r = 26'sd14668;
         5'd9:  r = 26'sd7334;
         5'd10: r = 26'sd3667;
         5'd11: r = 26'sd1833;
         5'd12: r = 26'sd917;
         5'd13: r = 26'sd458;
         5'd14: r = 26'sd229;
         5'd15: r = 26'sd115;
         5'd16: r = 26'sd57;
         5'd17: r = 26'sd29;
         5'd18: r = 26'sd14;
         5'd19: r = 26'sd7;
         5'd20: r = 26'sd4;
         5'd21: r = 26'sd2;
         5'd22: r = 26'sd1;
         default: r = 26'sd0;
      endcase
      return r;
   endfunction

   // Wraps an angle in 1/64 degree into (-HALF_TURN, HALF_TURN].
   function automatic logic signed [14:0] wrap_angle(input logic signed [17:0] v);
      logic signed [17:0] t;
      t = v;
      if (t > HALF_TURN) t = t - FULL_TURN;
      if (t > HALF_TURN) t = t - FULL_TURN;
      if (t <= -HALF_TURN) t = t + FULL_TURN;
      if (t <= -HALF_TURN) t = t + FULL_TURN;
      return t[14:0];
   endfunction

endpackage

// ----- rtl/wrf_ram.sv -----
module wrf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/wrf_dp.sv -----
module wrf_dp import wrf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   input  logic signed [15:0] req_pose_x_mm,
   input  logic signed [15:0] req_pose_y_mm,
   input  logic signed [8:0]  req_heading_deg,
   input  logic signed [15:0] req_point_x_mm,
   input  logic signed [15:0] req_point_y_mm
);

   logic signed [15:0] px_ff, py_ff, wx_ff, wy_ff;
   logic signed [8:0]  hd_ff;
   logic signed [15:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [16:0] dx_ff, dy_ff;
   logic               vzero_ff;
   logic signed [CX_W-1:0] cx_ff, cy_ff;
   logic signed [CZ_W-1:0] cz_ff;
   logic signed [14:0] err_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [34:0]        acc_ff;
   logic signed [13:0] turn_ff;
   logic [11:0]        ramp_ff, ramp_in;
   logic               arr_ff;

   logic [RAM_W-1:0]   rdata;
   logic signed [15:0] rx, ry;

   wrf_ram #(.WIDTH(RAM_W), .DEPTH(MAX_POINTS)) u_route (
      .clock (clock),
      .we    (cmd.ram_we),
      .addr  (cmd.ram_addr),
      .wdata ({wx_ff, wy_ff}),
      .rdata (rdata)
   );

   assign rx = rdata[31:16];
   assign ry = rdata[15:0];

   // Difference vector: point A minus pose, or point A minus point B.
   logic signed [16:0] dx_in, dy_in;
   assign dx_in = cmd.diff_pose ? 17'(ax_ff) - 17'(px_ff) : 17'(ax_ff) - 17'(bx_ff);
   assign dy_in = cmd.diff_pose ? 17'(ay_ff) - 17'(py_ff) : 17'(ay_ff) - 17'(by_ff);

   // CORDIC pre-rotation and micro-rotation
   logic signed [CX_W-1:0] ix, iy, sx, sy, xs, ys;
   logic signed [CZ_W-1:0] iz, sz, tab;
   always_comb begin
      ix = CX_W'(dx_ff);
      iy = CX_W'(dy_ff);
      iz = '0;
      if (dx_ff < 0) begin
         if (dy_ff >= 0) begin
            ix = CX_W'(dy_ff);
            iy = -CX_W'(dx_ff);
            iz = QUARTER_Z;
         end else begin
            ix = -CX_W'(dy_ff);
            iy = CX_W'(dx_ff);
            iz = -QUARTER_Z;
         end
      end
      xs  = cx_ff >>> cmd.iter;
      ys  = cy_ff >>> cmd.iter;
      tab = atan_tab(5'(cmd.iter));
      if (cy_ff > 0) begin
         sx = cx_ff + ys;
         sy = cy_ff - xs;
         sz = cz_ff + tab;
      end else begin
         sx = cx_ff - ys;
         sy = cy_ff + xs;
         sz = cz_ff - tab;
      end
   end

   // Heading error from the accumulated angle
   logic signed [CZ_W-1:0] zr;
   logic signed [17:0]     desired, err_raw;
   always_comb begin
      zr      = (cz_ff + CZ_W'(512)) >>> 10;
      desired = vzero_ff ? 18'sd0 : 18'(zr);
      err_raw = desired - 18'(signed'({hd_ff, 6'b0}));
   end

   logic [13:0] err_abs;
   assign err_abs = err_ff[14] ? 14'(-err_ff) : 14'(err_ff);

   // Shared multiplier
   logic signed [MUL_W-1:0] ma, mb;
   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.op)
         OP_MUL_TURN: begin
            ma = 18'(err_ff);
            mb = TURN_GAIN;
         end
         OP_MUL_SPD: begin
            ma = {6'b0, cfg.nominal};
            mb = 18'({4'b0, SLOW_END}) - 18'({4'b0, err_abs});
         end
         OP_MUL_RCP: begin
            ma = {1'b0, prod_ff[23:7]};
            mb = RCP_15;
         end
         OP_MUL_DX: begin
            ma = 18'(dx_ff);
            mb = 18'(dx_ff);
         end
         OP_MUL_DY: begin
            ma = 18'(dy_ff);
            mb = 18'(dy_ff);
         end
         OP_MUL_THR: begin
            ma = {6'b0, cfg.arrive_thr};
            mb = {6'b0, cfg.arrive_thr};
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   // Rounded, clamped proportional turn term, stored negated
   logic signed [PROD_W-1:0] tr;
   logic signed [19:0]       w, lim;
   always_comb begin
      tr  = prod_ff + PROD_W'(32768);
      w   = tr[35:16];
      lim = {7'b0, cfg.max_turn};
      if (w > lim) w = lim;
      if (w < -lim) w = -lim;
   end

   // Speed target and ramp
   logic [11:0] tgt;
   logic [12:0] up, dn_gap;
   always_comb begin
      if (err_abs <= SLOW_START) tgt = cfg.nominal;
      else if (err_abs >= SLOW_END) tgt = '0;
      else tgt = prod_ff[30:19];
      up     = 13'(ramp_ff) + 13'(cfg.ramp_step);
      dn_gap = 13'(ramp_ff) - 13'(tgt);
      ramp_in = ramp_ff;
      if (ramp_ff < tgt) begin
         ramp_in = (up > 13'(tgt)) ? tgt : up[11:0];
      end else if (ramp_ff > tgt) begin
         ramp_in = (dn_gap > 13'(cfg.ramp_step)) ? ramp_ff - 12'(cfg.ramp_step) : tgt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_ff <= '0;
      end else if (cmd.op == OP_RAMP) begin
         ramp_ff <= ramp_in;
      end else if (cmd.op == OP_CLR_SPD) begin
         ramp_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            px_ff <= req_pose_x_mm;
            py_ff <= req_pose_y_mm;
            hd_ff <= req_heading_deg;
            wx_ff <= req_point_x_mm;
            wy_ff <= req_point_y_mm;
         end
         OP_LD_A: begin
            ax_ff <= rx;
            ay_ff <= ry;
         end
         OP_LD_B: begin
            bx_ff <= rx;
            by_ff <= ry;
         end
         OP_DIFF: begin
            dx_ff    <= dx_in;
            dy_ff    <= dy_in;
            vzero_ff <= (dx_in == 17'sd0) && (dy_in == 17'sd0);
         end
         OP_CINIT: begin
            cx_ff <= ix;
            cy_ff <= iy;
            cz_ff <= iz;
         end
         OP_CSTEP: begin
            cx_ff <= sx;
            cy_ff <= sy;
            cz_ff <= sz;
         end
         OP_ANGLE:    err_ff <= wrap_angle(err_raw);
         OP_MUL_TURN,
         OP_MUL_SPD,
         OP_MUL_RCP,
         OP_MUL_DX:   prod_ff <= ma * mb;
         OP_MUL_DY: begin
            acc_ff  <= 35'(prod_ff);
            prod_ff <= ma * mb;
         end
         OP_MUL_THR: begin
            acc_ff  <= acc_ff + 35'(prod_ff);
            prod_ff <= ma * mb;
         end
         OP_TURN:     turn_ff <= 14'(-w);
         OP_ARR:      arr_ff <= (36'(acc_ff) <= 36'(prod_ff));
         default: begin
         end
      endcase
   end

   assign stat.a_zero   = (ax_ff == 16'sd0) && (ay_ff == 16'sd0);
   assign stat.aligned  = (err_ff < ALIGN_TOL) && (err_ff > -ALIGN_TOL);
   assign stat.arrived  = arr_ff;
   assign stat.ramped   = ramp_ff;
   assign stat.turn_neg = turn_ff;

endmodule

// ----- rtl/wrf_ctrl.sv -----
module wrf_ctrl import wrf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [SLOT_W-1:0]  req_point_slot,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [11:0]        rsp_speed_req_mm_s,
   output logic signed [13:0] rsp_turn_req_mrad_s,
   output logic               rsp_running,
   output logic [2:0]         rsp_phase,
   output logic [SLOT_W-1:0]  rsp_target_slot,
   output logic               rsp_odometry_clear,
   output dp_cmd_type         cmd,
   input  dp_stat_type        stat
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_DEC   = 5'd1;
   localparam logic [4:0] S_RD1   = 5'd2;
   localparam logic [4:0] S_LD1   = 5'd3;
   localparam logic [4:0] S_LD2   = 5'd4;
   localparam logic [4:0] S_DIFF  = 5'd5;
   localparam logic [4:0] S_CINIT = 5'd6;
   localparam logic [4:0] S_CSTEP = 5'd7;
   localparam logic [4:0] S_ANG   = 5'd8;
   localparam logic [4:0] S_MT    = 5'd9;
   localparam logic [4:0] S_TURN  = 5'd10;
   localparam logic [4:0] S_MS    = 5'd11;
   localparam logic [4:0] S_MR    = 5'd12;
   localparam logic [4:0] S_RAMP  = 5'd13;
   localparam logic [4:0] S_MX    = 5'd14;
   localparam logic [4:0] S_MY    = 5'd15;
   localparam logic [4:0] S_MTH   = 5'd16;
   localparam logic [4:0] S_ARR   = 5'd17;
   localparam logic [4:0] S_FIN   = 5'd18;

   function automatic logic [SLOT_W-1:0] next_of(input logic [SLOT_W-1:0] i,
                                                 input logic [LEN_W-1:0] len);
      return ((LEN_W'(i) + LEN_W'(1)) < len) ? i + SLOT_W'(1) : i;
   endfunction

   logic [4:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [1:0]        func_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [2:0]        phase_ff, phase_in;
   logic              active_ff, active_in;
   logic [SLOT_W-1:0] target_ff, target_in, look_ff, look_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [11:0]        spd_ff, spd_in;
   logic signed [13:0] turn_ff, turn_in;
   logic               clr_ff, clr_in;

   logic [LEN_W-1:0] len;
   logic             out_free, commit, run_tick, target_out;

   assign len        = (cfg.route_length > LEN_W'(MAX_POINTS)) ? LEN_W'(MAX_POINTS)
                                                               : cfg.route_length;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign commit     = (state_ff == S_FIN) && out_free;
   assign run_tick   = (func_ff == FN_TICK) && active_ff && (len != '0);
   assign target_out = LEN_W'(target_ff) >= len;
   assign req_ready  = (state_ff == S_IDLE);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      cmd          = '0;
      cmd.op       = OP_NONE;
      cmd.diff_pose = (phase_ff != PH_ALIGN_NEXT);
      cmd.iter     = iter_ff;
      cmd.ram_addr = target_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            state_in = S_FIN;
            if (run_tick && ((phase_ff == PH_ALIGN_FIRST) || (phase_ff == PH_DRIVE_FIRST)
                             || (phase_ff == PH_ALIGN_NEXT)
                             || ((phase_ff == PH_FOLLOW) && !target_out))) begin
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            cmd.ram_addr = (phase_ff == PH_ALIGN_NEXT) ? look_ff : target_ff;
            state_in     = S_LD1;
         end
         S_LD1: begin
            cmd.op   = OP_LD_A;
            state_in = (phase_ff == PH_ALIGN_NEXT) ? S_LD2 : S_DIFF;
         end
         S_LD2: begin
            cmd.op   = OP_LD_B;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            if ((phase_ff == PH_ALIGN_FIRST) && (target_ff == '0) && stat.a_zero) begin
               state_in = S_FIN;
            end else begin
               cmd.op   = OP_DIFF;
               state_in = S_CINIT;
            end
         end
         S_CINIT: begin
            cmd.op   = OP_CINIT;
            iter_in  = '0;
            state_in = S_CSTEP;
         end
         S_CSTEP: begin
            cmd.op  = OP_CSTEP;
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(CORDIC_STEPS - 1)) begin
               iter_in  = '0;
               state_in = S_ANG;
            end
         end
         S_ANG: begin
            cmd.op   = OP_ANGLE;
            state_in = S_MT;
         end
         S_MT: begin
            cmd.op   = OP_MUL_TURN;
            state_in = S_TURN;
         end
         S_TURN: begin
            cmd.op   = OP_TURN;
            state_in = ((phase_ff == PH_ALIGN_FIRST) || (phase_ff == PH_ALIGN_NEXT))
                       ? S_FIN : S_MS;
         end
         S_MS: begin
            cmd.op   = OP_MUL_SPD;
            state_in = S_MR;
         end
         S_MR: begin
            cmd.op   = OP_MUL_RCP;
            state_in = S_RAMP;
         end
         S_RAMP: begin
            cmd.op   = OP_RAMP;
            state_in = S_MX;
         end
         S_MX: begin
            cmd.op   = OP_MUL_DX;
            state_in = S_MY;
         end
         S_MY: begin
            cmd.op   = OP_MUL_DY;
            state_in = S_MTH;
         end
         S_MTH: begin
            cmd.op   = OP_MUL_THR;
            state_in = S_ARR;
         end
         S_ARR: begin
            cmd.op   = OP_ARR;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.ram_addr = slot_ff;
            if (out_free) begin
               state_in = S_IDLE;
               if ((func_ff == FN_START) || (func_ff == FN_STOP)) begin
                  cmd.op = OP_CLR_SPD;
               end
               cmd.ram_we = (func_ff == FN_WRITE) && (32'(slot_ff) < MAX_POINTS);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Route state update and result, applied when the result is committed
   always_comb begin
      phase_in  = phase_ff;
      active_in = active_ff;
      target_in = target_ff;
      look_in   = look_ff;
      wait_in   = wait_ff;
      spd_in    = '0;
      turn_in   = '0;
      clr_in    = 1'b0;
      if (func_ff == FN_START) begin
         target_in = '0;
         look_in   = '0;
         active_in = 1'b1;
         phase_in  = PH_WAIT;
         wait_in   = '0;
         clr_in    = 1'b1;
      end else if (func_ff == FN_STOP) begin
         target_in = '0;
         look_in   = '0;
         active_in = 1'b0;
         phase_in  = PH_IDLE;
         clr_in    = 1'b1;
      end else if (run_tick) begin
         case (phase_ff)
            PH_WAIT: begin
               if (32'(wait_ff) >= WAIT_TICKS) begin
                  target_in = '0;
                  look_in   = (len > LEN_W'(1)) ? SLOT_W'(1) : '0;
                  phase_in  = PH_ALIGN_FIRST;
               end else begin
                  wait_in = wait_ff + WAIT_W'(1);
               end
            end
            PH_ALIGN_FIRST: begin
               if ((target_ff == '0) && stat.a_zero) begin
                  if (len > LEN_W'(1)) begin
                     look_in  = SLOT_W'(1);
                     phase_in = PH_ALIGN_NEXT;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end else if (stat.aligned) begin
                  phase_in = PH_DRIVE_FIRST;
               end else begin
                  turn_in = stat.turn_neg;
               end
            end
            PH_DRIVE_FIRST, PH_FOLLOW: begin
               if ((phase_ff == PH_FOLLOW) && target_out) begin
                  phase_in = PH_DONE;
               end else begin
                  spd_in  = stat.ramped;
                  turn_in = stat.turn_neg;
                  if (stat.arrived) begin
                     if (phase_ff == PH_DRIVE_FIRST) begin
                        if (len > LEN_W'(1)) begin
                           look_in  = next_of(target_ff, len);
                           phase_in = PH_ALIGN_NEXT;
                        end else begin
                           spd_in   = '0;
                           turn_in  = '0;
                           phase_in = PH_DONE;
                        end
                     end else if ((LEN_W'(target_ff) + LEN_W'(1)) < len) begin
                        target_in = target_ff + SLOT_W'(1);
                        look_in   = next_of(target_ff + SLOT_W'(1), len);
                     end else if (cfg.loop_route) begin
                        target_in = '0;
                        look_in   = (len > LEN_W'(1)) ? SLOT_W'(1) : '0;
                     end else begin
                        spd_in   = '0;
                        turn_in  = '0;
                        phase_in = PH_DONE;
                     end
                  end
               end
            end
            PH_ALIGN_NEXT: begin
               if (stat.aligned) begin
                  target_in = look_ff;
                  look_in   = next_of(look_ff, len);
                  phase_in  = PH_FOLLOW;
               end else begin
                  turn_in = stat.turn_neg;
               end
            end
            PH_DONE: begin
               active_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         phase_ff     <= PH_IDLE;
         active_ff    <= 1'b0;
         target_ff    <= '0;
         look_ff      <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            phase_ff  <= phase_in;
            active_ff <= active_in;
            target_ff <= target_in;
            look_ff   <= look_in;
            wait_ff   <= wait_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff <= req_func;
         slot_ff <= req_point_slot;
      end
      if (commit) begin
         spd_ff  <= spd_in;
         turn_ff <= turn_in;
         clr_ff  <= clr_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_speed_req_mm_s  = spd_ff;
   assign rsp_turn_req_mrad_s = turn_ff;
   assign rsp_running         = active_ff;
   assign rsp_phase           = phase_ff;
   assign rsp_target_slot     = target_ff;
   assign rsp_odometry_clear  = clr_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("controller took a transaction without leaving idle");

   a_never_idle_active: assert property (@(posedge clock) disable iff (reset)
      !((phase_ff == PH_IDLE) && active_ff))
      else $error("route is active while the phase is idle");

   a_write_only_on_store: assert property (@(posedge clock) disable iff (reset)
      cmd.ram_we |-> ((func_ff == FN_WRITE) && (state_ff == S_FIN)))
      else $error("waypoint table written outside a waypoint store");

   a_iter_only_in_cordic: assert property (@(posedge clock) disable iff (reset)
      (iter_ff != '0) |-> (state_ff == S_CSTEP))
      else $error("CORDIC step count left nonzero outside the iteration");

endmodule

// ----- rtl/waypoint_route_follower.sv -----
// Waypoint route follower. Each request transaction is a 10 ms tick that carries the odometry
// pose, a start or stop event, or a waypoint store into the 64-entry route table; every request
// yields exactly one response transaction with a linear and an angular speed request, the
// route status and an odometry clear flag. The block works on one request at a time. Start,
// stop, store and ticks that need no geometry go from decode straight to the response, and a
// tick that finds the first waypoint at the origin reads that waypoint and stops there. Ticks
// that steer read the target (align first, drive phases) or two waypoints (align next), run
// the sixteen-iteration CORDIC atan2 and then use the single shared 18 x 18 multiplier in turn
// for the turn term and, in the drive phases, for the speed slowdown and the squared arrival
// distance. A new request is accepted in the cycle after the previous one has been placed in
// the response register, even while that response still waits for the consumer. Configuration
// registers on the APB port sit at byte addresses 4*i and must only be written while the block
// is idle.
module waypoint_route_follower import wrf_pkg::*; (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic signed [15:0] req_pose_x_mm,
   input  logic signed [15:0] req_pose_y_mm,
   input  logic signed [8:0]  req_heading_deg,
   input  logic [5:0]         req_point_slot,
   input  logic signed [15:0] req_point_x_mm,
   input  logic signed [15:0] req_point_y_mm,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [11:0]        rsp_speed_req_mm_s,
   output logic signed [13:0] rsp_turn_req_mrad_s,
   output logic               rsp_running,
   output logic [2:0]         rsp_phase,
   output logic [5:0]         rsp_target_slot,
   output logic               rsp_odometry_clear,

   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // Configuration registers. A write lands at the access phase of the APB transaction;
   // the register index is taken from the word address and unused indexes are ignored.
   cfg_type     cfg_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.route_length <= '0;
         cfg_ff.arrive_thr   <= 12'd100;
         cfg_ff.nominal      <= 12'd250;
         cfg_ff.max_turn     <= 13'd2000;
         cfg_ff.loop_route   <= 1'b0;
         cfg_ff.ramp_step    <= 8'd4;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ROUTE_LEN: cfg_ff.route_length <= csr_pwdata[LEN_W-1:0];
            REG_ARRIVE:    cfg_ff.arrive_thr   <= csr_pwdata[11:0];
            REG_NOMINAL:   cfg_ff.nominal      <= csr_pwdata[11:0];
            REG_MAX_TURN:  cfg_ff.max_turn     <= csr_pwdata[12:0];
            REG_LOOP:      cfg_ff.loop_route   <= csr_pwdata[0];
            REG_RAMP:      cfg_ff.ramp_step    <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Read data simply reflects the addressed register.
   always_comb begin
      unique case (csr_index)
         REG_ROUTE_LEN: csr_prdata = 32'(cfg_ff.route_length);
         REG_ARRIVE:    csr_prdata = 32'(cfg_ff.arrive_thr);
         REG_NOMINAL:   csr_prdata = 32'(cfg_ff.nominal);
         REG_MAX_TURN:  csr_prdata = 32'(cfg_ff.max_turn);
         REG_LOOP:      csr_prdata = 32'(cfg_ff.loop_route);
         REG_RAMP:      csr_prdata = 32'(cfg_ff.ramp_step);
         default:       csr_prdata = '0;
      endcase
   end

   // The controller sequences each request and owns the route phase, indexes and the
   // response register; the datapath holds the table, CORDIC, multiplier and speed ramp.
   dp_cmd_type  cmd;
   dp_stat_type stat;

   wrf_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_point_slot      (req_point_slot),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_speed_req_mm_s  (rsp_speed_req_mm_s),
      .rsp_turn_req_mrad_s (rsp_turn_req_mrad_s),
      .rsp_running         (rsp_running),
      .rsp_phase           (rsp_phase),
      .rsp_target_slot     (rsp_target_slot),
      .rsp_odometry_clear  (rsp_odometry_clear),
      .cmd                 (cmd),
      .stat                (stat)
   );

   wrf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .stat            (stat),
      .req_pose_x_mm   (req_pose_x_mm),
      .req_pose_y_mm   (req_pose_y_mm),
      .req_heading_deg (req_heading_deg),
      .req_point_x_mm  (req_point_x_mm),
      .req_point_y_mm  (req_point_y_mm)
   );

endmodule
